FILE: src/bitmap_glyph_text_renderer_assert.svh
// Assertion macros shared by the glyph renderer modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BITMAP_GLYPH_TEXT_RENDERER_ASSERT_SVH
`define BITMAP_GLYPH_TEXT_RENDERER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define BGTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bgtr_pkg.sv
// Types and constants shared by the bitmap glyph renderer.
// No dependencies; every module of the block imports it.
`default_nettype none

package bgtr_pkg;

    // Field widths of the stream payloads.
    localparam int CODE_W    = 9;
    localparam int SIZE_W    = 6;
    localparam int OFF_W     = 7;
    localparam int ADV_W     = 8;
    localparam int ROW_IDX_W = 5;
    localparam int ROW_W     = 32;
    localparam int POS_W     = 16;
    localparam int PITCH_W   = 16;
    localparam int COLOR_W   = 32;
    localparam int ADDR_W    = 32;

    localparam int IN_TDATA_W  = 120;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Character code that starts a new line.
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 9'd10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FB_PITCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 2'd3;

    // Input item kinds.
    typedef enum logic [1:0] {
        FUNC_PEN  = 2'd0,
        FUNC_DRAW = 2'd1,
        FUNC_META = 2'd2,
        FUNC_ROW  = 2'd3
    } func_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_FALL,
        ST_ADDR,
        ST_ROWS
    } state_t;

    // One entry of the glyph metrics store.
    typedef struct packed {
        logic                    valid;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
        logic signed [OFF_W-1:0] xoff;
        logic signed [OFF_W-1:0] yoff;
        logic [ADV_W-1:0]        adv;
    } meta_t;

    // Command that starts the row emitter on one glyph.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  h;
        logic [ROW_W-1:0]   wmask;
        logic [COLOR_W-1:0] color;
    } emit_cmd_t;

endpackage

`default_nettype wire

FILE: src/bgtr_meta_mem.sv
// Glyph metrics store: one write port, one read port with registered data.
// Depends on bgtr_pkg for the entry type.
`default_nettype none

module bgtr_meta_mem #(
    parameter int DEPTH = 257,
    parameter int AW    = 9
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  bgtr_pkg::meta_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output bgtr_pkg::meta_t rdata
);
    import bgtr_pkg::*;

    meta_t mem [DEPTH];
    meta_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/bgtr_row_mem.sv
// Glyph bitmap row store: one write port, one read port with registered data.
// Depends on bgtr_pkg for the row width.
`default_nettype none

module bgtr_row_mem #(
    parameter int DEPTH = 8224,
    parameter int AW    = 14
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [bgtr_pkg::ROW_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [bgtr_pkg::ROW_W-1:0] rdata
);
    import bgtr_pkg::*;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/bgtr_emit.sv
// Row emitter: reads a glyph row per cycle unless stalled; drives output register.
// Depends on bgtr_pkg and the assertion macro header.
`default_nettype none
`include "bitmap_glyph_text_renderer_assert.svh"

module bgtr_emit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  bgtr_pkg::emit_cmd_t              cmd,
    input  logic [bgtr_pkg::PITCH_W-1:0]     pitch,
    output logic                             rd_en,
    output logic [bgtr_pkg::ROW_IDX_W-1:0]   rd_row,
    input  logic [bgtr_pkg::ROW_W-1:0]       rd_data,
    output logic                             done,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: row_address[31:0], pixel_mask[63:32], pixel_color[95:64].
    output logic [bgtr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);
    import bgtr_pkg::*;

    // Control state.
    logic              busy_reg;
    logic              pend_reg;
    logic              out_valid_reg;
    logic [SIZE_W-1:0] iss_reg;

    // Glyph and row payload.
    logic [SIZE_W-1:0]  h_reg;
    logic [ROW_W-1:0]   wmask_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               pend_last_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [ROW_W-1:0]   out_mask_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    logic              load;
    logic [SIZE_W-1:0] iss_inc;
    logic              iss_last;

    // A pending row moves to the output register when that is free or being taken;
    // the next read is issued when the read data register is free or being emptied.
    assign load     = pend_reg && (!out_valid_reg || m_axis_tready);
    assign rd_en    = busy_reg && (!pend_reg || load);
    assign rd_row   = iss_reg[ROW_IDX_W-1:0];
    assign iss_inc  = iss_reg + 6'd1;
    assign iss_last = (iss_inc == h_reg);
    assign done     = load && pend_last_reg;

    // Row sequencing and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            iss_reg       <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                iss_reg  <= '0;
            end
            else if (rd_en)
            begin
                iss_reg <= iss_inc;
                if (iss_last)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (rd_en)
            begin
                pend_reg <= 1'b1;
            end
            else if (load)
            begin
                pend_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: glyph command, running address and output register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg     <= cmd.h;
            wmask_reg <= cmd.wmask;
            color_reg <= cmd.color;
        end

        if (rd_en)
        begin
            pend_last_reg <= iss_last;
        end

        if (start)
        begin
            addr_reg <= cmd.addr;
        end
        else if (load)
        begin
            addr_reg <= addr_reg + {16'd0, pitch};
        end

        if (load)
        begin
            out_addr_reg  <= addr_reg;
            out_mask_reg  <= rd_data & wmask_reg;
            out_color_reg <= color_reg;
            out_last_reg  <= pend_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_color_reg, out_mask_reg, out_addr_reg};
    assign m_axis_tlast  = out_last_reg;

    `BGTR_ASSERT(a_start_when_empty, start |-> (!busy_reg && !pend_reg), "start while busy")
    `BGTR_ASSERT_NEXT(a_read_fills_pend, rd_en, pend_reg, "row read lost")
    `BGTR_ASSERT(a_done_after_issue, done |-> !busy_reg, "last row emitted early")

endmodule

`default_nettype wire

FILE: src/bitmap_glyph_text_renderer.sv
// Bitmap glyph text renderer top level: control sequencer, pen and
// configuration registers, and the two glyph stores. Depends on bgtr_pkg,
// bgtr_meta_mem, bgtr_row_mem, bgtr_emit and the assertion macro header.
//
// After reset the block runs a clearing pass over the metrics store, one slot
// a cycle up to the fallback slot, during which no input item is taken
// (configuration writes are taken at all times). Pen, metrics and row items
// are handled as they are taken, as is a newline. A drawn character goes
// through lookup (and the fallback slot when consulted) and address set-up,
// then one glyph row per cycle while the output is not held back, set by the
// single read port of the row store; the input waits until the last row is in
// the output register, where it may still wait while the next item is taken.
`default_nettype none
`include "bitmap_glyph_text_renderer_assert.svh"

module bitmap_glyph_text_renderer #(
    parameter int NUM_CODES   = 256,
    parameter int MAX_GLYPH_W = 32,
    parameter int MAX_GLYPH_H = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: code[8:0], glyph_present[9], glyph_width[15:10],
    // glyph_height[21:16], x_offset[28:22], y_offset[35:29], advance[43:36],
    // row_index[48:44], row_bits[80:49], pos_x[96:81], pos_y[112:97], zero fill.
    input  logic [bgtr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [bgtr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: row_address[31:0], pixel_mask[63:32], pixel_color[95:64].
    output logic [bgtr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bgtr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgtr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bgtr_pkg::*;

    localparam int SLOTS     = NUM_CODES + 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ROW_AW    = SLOT_W + ROW_IDX_W;
    localparam int ROW_DEPTH = SLOTS * (2 ** ROW_IDX_W);
    localparam int W_CAP     = (MAX_GLYPH_W < 32) ? MAX_GLYPH_W : 32;
    localparam int H_CAP     = (MAX_GLYPH_H < 32) ? MAX_GLYPH_H : 32;
    localparam logic [SLOT_W-1:0] FALLBACK = SLOT_W'(NUM_CODES);

    // Input item fields.
    func_t                   in_func;
    logic [CODE_W-1:0]       in_code;
    logic                    in_present;
    logic [SIZE_W-1:0]       in_gw;
    logic [SIZE_W-1:0]       in_gh;
    logic signed [OFF_W-1:0] in_xoff;
    logic signed [OFF_W-1:0] in_yoff;
    logic [ADV_W-1:0]        in_adv;
    logic [ROW_IDX_W-1:0]    in_row_idx;
    logic [ROW_W-1:0]        in_row_bits;
    logic [POS_W-1:0]        in_pos_x;
    logic [POS_W-1:0]        in_pos_y;

    assign in_func     = func_t'(s_axis_tuser);
    assign in_code     = s_axis_tdata[8:0];
    assign in_present  = s_axis_tdata[9];
    assign in_gw       = s_axis_tdata[15:10];
    assign in_gh       = s_axis_tdata[21:16];
    assign in_xoff     = s_axis_tdata[28:22];
    assign in_yoff     = s_axis_tdata[35:29];
    assign in_adv      = s_axis_tdata[43:36];
    assign in_row_idx  = s_axis_tdata[48:44];
    assign in_row_bits = s_axis_tdata[80:49];
    assign in_pos_x    = s_axis_tdata[96:81];
    assign in_pos_y    = s_axis_tdata[112:97];

    // Registers.
    state_t              state_reg;
    state_t              state_next;
    logic [SLOT_W-1:0]   clr_reg;
    logic [PITCH_W-1:0]  pitch_reg;
    logic [SIZE_W-1:0]   fw_reg;
    logic [SIZE_W-1:0]   fh_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [POS_W-1:0]    pen_x_reg;
    logic [POS_W-1:0]    pen_y_reg;
    logic [POS_W-1:0]    line_x_reg;
    logic [SLOT_W-1:0]   slot_reg;
    meta_t               glyph_reg;
    logic signed [16:0]  px_reg;
    logic signed [16:0]  py_reg;

    // Handshakes and decoded item kinds.
    logic              in_accept;
    logic              cfg_accept;
    logic              is_newline;
    logic              draw_go;
    logic [SLOT_W-1:0] in_slot;
    meta_t             meta_new;

    // Store ports.
    logic              meta_we;
    logic [SLOT_W-1:0] meta_waddr;
    meta_t             meta_wdata;
    logic              meta_re;
    logic [SLOT_W-1:0] meta_raddr;
    meta_t             meta_rdata;
    logic              row_we;
    logic              row_re;
    logic [ROW_IDX_W-1:0] emit_row;
    logic [ROW_W-1:0]  row_rdata;

    // Row emitter link.
    logic              emit_start;
    logic              emit_done;
    emit_cmd_t         emit_cmd;

    // Address set-up and pen advance.
    logic signed [33:0] start_prod;
    logic [POS_W-1:0]   adv_amt;
    logic               glyph_end;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign is_newline = (in_code == NEWLINE_CODE);
    assign draw_go    = in_accept && (in_func == FUNC_DRAW) && !is_newline;
    assign in_slot    = (32'(in_code) < 32'(NUM_CODES)) ? SLOT_W'(in_code) : FALLBACK;

    // Metrics entry from a metrics write, sizes saturated.
    always_comb
    begin
        meta_new.valid = in_present;
        meta_new.w     = (in_gw > SIZE_W'(W_CAP)) ? SIZE_W'(W_CAP) : in_gw;
        meta_new.h     = (in_gh > SIZE_W'(H_CAP)) ? SIZE_W'(H_CAP) : in_gh;
        meta_new.xoff  = in_xoff;
        meta_new.yoff  = in_yoff;
        meta_new.adv   = in_adv;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == FALLBACK)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (draw_go)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = meta_rdata.valid ? ST_ADDR : ST_FALL;
            end
            ST_FALL:
            begin
                state_next = meta_rdata.valid ? ST_ADDR : ST_IDLE;
            end
            ST_ADDR:
            begin
                state_next = (glyph_reg.h == '0) ? ST_IDLE : ST_ROWS;
            end
            ST_ROWS:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and store port control.
    always_comb
    begin
        s_axis_tready = 1'b0;
        meta_we       = 1'b0;
        meta_waddr    = in_slot;
        meta_wdata    = meta_new;
        meta_re       = 1'b0;
        meta_raddr    = in_slot;
        row_we        = 1'b0;
        emit_start    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = '0;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                meta_we       = in_accept && (in_func == FUNC_META);
                row_we        = in_accept && (in_func == FUNC_ROW);
                meta_re       = draw_go;
            end
            ST_LOOK:
            begin
                meta_re    = !meta_rdata.valid;
                meta_raddr = FALLBACK;
            end
            ST_ADDR:
            begin
                emit_start = (glyph_reg.h != '0);
            end
            ST_FALL, ST_ROWS:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // State and clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= 16'd640;
            fw_reg    <= 6'd8;
            fh_reg    <= 6'd16;
            color_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_FB_PITCH:    pitch_reg <= cfg_data[PITCH_W-1:0];
                CFG_FONT_WIDTH:  fw_reg    <= cfg_data[SIZE_W-1:0];
                CFG_FONT_HEIGHT: fh_reg    <= cfg_data[SIZE_W-1:0];
                CFG_FG_COLOR:    color_reg <= cfg_data;
            endcase
        end
    end

    // Pen advance: glyph advance, or font width when that is zero.
    assign adv_amt   = (glyph_reg.adv != '0) ? POS_W'(glyph_reg.adv) : POS_W'(fw_reg);
    assign glyph_end = ((state_reg == ST_ADDR) && (glyph_reg.h == '0))
                       || ((state_reg == ST_ROWS) && emit_done);

    // Pen registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            line_x_reg <= '0;
        end
        else if (in_accept && (in_func == FUNC_PEN))
        begin
            pen_x_reg  <= in_pos_x;
            line_x_reg <= in_pos_x;
            pen_y_reg  <= in_pos_y;
        end
        else if (in_accept && (in_func == FUNC_DRAW) && is_newline)
        begin
            pen_x_reg <= line_x_reg;
            pen_y_reg <= pen_y_reg + POS_W'(fh_reg);
        end
        else if ((state_reg == ST_FALL) && !meta_rdata.valid)
        begin
            pen_x_reg <= pen_x_reg + POS_W'(fw_reg);
        end
        else if (glyph_end)
        begin
            pen_x_reg <= pen_x_reg + adv_amt;
        end
    end

    // Slot and glyph capture for the draw in progress.
    always_ff @(posedge clk)
    begin
        if (draw_go)
        begin
            slot_reg <= in_slot;
        end
        else if ((state_reg == ST_LOOK) && !meta_rdata.valid)
        begin
            slot_reg <= FALLBACK;
        end

        if (((state_reg == ST_LOOK) || (state_reg == ST_FALL)) && meta_rdata.valid)
        begin
            glyph_reg <= meta_rdata;
            px_reg    <= {pen_x_reg[POS_W-1], pen_x_reg}
                         + {{(17 - OFF_W){meta_rdata.xoff[OFF_W-1]}}, meta_rdata.xoff};
            py_reg    <= {pen_y_reg[POS_W-1], pen_y_reg}
                         + {{(17 - OFF_W){meta_rdata.yoff[OFF_W-1]}}, meta_rdata.yoff};
        end
    end

    // First row address and mask for the emitter.
    assign start_prod = py_reg * $signed({1'b0, pitch_reg});

    always_comb
    begin
        emit_cmd.addr  = start_prod[ADDR_W-1:0] + {{15{px_reg[16]}}, px_reg};
        emit_cmd.h     = glyph_reg.h;
        emit_cmd.wmask = ~(32'hFFFF_FFFF >> glyph_reg.w);
        emit_cmd.color = color_reg;
    end

    bgtr_meta_mem #(
        .DEPTH (SLOTS),
        .AW    (SLOT_W)
    ) u_meta_mem (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    bgtr_row_mem #(
        .DEPTH (ROW_DEPTH),
        .AW    (ROW_AW)
    ) u_row_mem (
        .clk   (clk),
        .we    (row_we),
        .waddr ({in_slot, in_row_idx}),
        .wdata (in_row_bits),
        .re    (row_re),
        .raddr ({slot_reg, emit_row}),
        .rdata (row_rdata)
    );

    bgtr_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (emit_start),
        .cmd           (emit_cmd),
        .pitch         (pitch_reg),
        .rd_en         (row_re),
        .rd_row        (emit_row),
        .rd_data       (row_rdata),
        .done          (emit_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `BGTR_ASSERT(a_done_in_rows, emit_done |-> (state_reg == ST_ROWS), "emitter done outside row phase")
    `BGTR_ASSERT(a_one_store_write, row_we |-> !meta_we, "both stores written by one item")
    `BGTR_ASSERT_NEXT(a_meta_read_used, meta_re, ((state_reg == ST_LOOK) || (state_reg == ST_FALL)), "metrics read not consumed")

endmodule

`default_nettype wire
